FILE: src/lrut_pkg.sv
// Package for the least-recently-used page tracker.
// Holds sizes, mode codes and sequencer states; no dependencies.
package lrut_pkg;

  localparam int NumSlots = 16;
  localparam int SlotIdxW = $clog2(NumSlots);
  localparam int CountW   = $clog2(NumSlots + 1);
  localparam int KeyW     = 64;
  localparam int PageW    = 16;
  localparam int ModeW    = 2;
  localparam int CapW     = 5;
  localparam int OccW     = 5;
  localparam int CmpW     = (CountW > CapW) ? CountW : CapW;

  localparam logic [CapW-1:0] CapReset = CapW'(NumSlots);

  typedef enum logic [ModeW-1:0] {
    MODE_ACCESS = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

endpackage

FILE: src/lru_replacement_tracker.sv
// Least-recently-used tracker for buffer-pool pages: top level.
// Depends on lrut_pkg for sizes, mode codes and sequencer states.
//
// Usage: drive mode_i, entry_key_i and page_id_i and raise start; the request
// is taken at a rising edge where start is high and busy is low. busy stays
// high while the request is worked on. A single compare unit walks the slots
// one per cycle, looking for the page, the oldest entry and the first free
// slot; an update step then writes valid bits, age ranks and counts. The
// result shows on hit_o, evicted_valid_o, evicted_key_o, evicted_page_o and
// occupancy_o for exactly one cycle with result_valid_o high, registered from
// the update step; busy is already low while it is shown, so the next request
// can be taken at the edge that ends it. The receiver cannot stall: every
// result must be taken in the cycle it is shown. Capacity is written through
// cfg_we_i and cfg_data_i while the block is idle, a user rule the block does
// not enforce. Reset empties the tracker, sets capacity to 16 and returns to
// idle; key and page storage is not cleared and is read only where valid.
module lru_replacement_tracker
  import lrut_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CapW-1:0]  cfg_data_i,
  input  logic             start,
  output logic             busy,
  input  logic [ModeW-1:0] mode_i,
  input  logic [KeyW-1:0]  entry_key_i,
  input  logic [PageW-1:0] page_id_i,
  output logic             result_valid_o,
  output logic             hit_o,
  output logic             evicted_valid_o,
  output logic [KeyW-1:0]  evicted_key_o,
  output logic [PageW-1:0] evicted_page_o,
  output logic [OccW-1:0]  occupancy_o
);

  state_e state_q, state_d;

  logic [CapW-1:0]     cap_q;
  logic [CountW-1:0]   count_q;
  logic [NumSlots-1:0] valid_q;
  logic [SlotIdxW-1:0] rank_q [NumSlots];
  logic [KeyW-1:0]     key_mem [NumSlots];
  logic [PageW-1:0]    page_mem [NumSlots];

  logic [ModeW-1:0]    mode_q;
  logic [KeyW-1:0]     req_key_q;
  logic [PageW-1:0]    req_page_q;
  logic [SlotIdxW-1:0] idx_q;

  logic                hit_found_q, old_found_q, free_found_q;
  logic [SlotIdxW-1:0] hit_idx_q, old_idx_q, free_idx_q;
  logic [SlotIdxW-1:0] hit_rank_q, old_rank_q;
  logic [KeyW-1:0]     old_key_q;
  logic [PageW-1:0]    old_page_q;

  logic                res_valid_q, res_hit_q, res_ev_q;
  logic [KeyW-1:0]     res_key_q;
  logic [PageW-1:0]    res_page_q;
  logic [OccW-1:0]     res_occ_q;

  logic                accept;
  logic                scan_last;
  logic                cur_valid, cur_match, cur_older;
  logic [SlotIdxW-1:0] cur_rank;

  logic [CmpW-1:0]     eff_cap;
  logic                is_access, is_remove, is_clear;
  logic                acc_hit, acc_miss, evict, ins_ok, rem_hit;
  logic [SlotIdxW-1:0] ins_idx;
  logic [CountW-1:0]   count_new;

  assign accept    = start && (state_q == ST_IDLE);
  assign busy      = (state_q != ST_IDLE);
  assign scan_last = (idx_q == SlotIdxW'(NumSlots - 1));

  // shared compare unit over the slot at the scan index
  assign cur_valid = valid_q[idx_q];
  assign cur_rank  = rank_q[idx_q];
  assign cur_match = cur_valid && (page_mem[idx_q] == req_page_q);
  assign cur_older = cur_valid && (!old_found_q || (cur_rank >= old_rank_q));

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CmpW'(1);
    end else if (CmpW'(cap_q) > CmpW'(NumSlots)) begin
      eff_cap = CmpW'(NumSlots);
    end else begin
      eff_cap = CmpW'(cap_q);
    end
  end

  assign is_access = (mode_q == MODE_ACCESS);
  assign is_remove = (mode_q == MODE_REMOVE);
  assign is_clear  = (mode_q == MODE_CLEAR);
  assign acc_hit   = is_access && hit_found_q;
  assign acc_miss  = is_access && !hit_found_q;
  assign rem_hit   = is_remove && hit_found_q;
  assign evict     = acc_miss && old_found_q && (count_q != '0) &&
                     (CmpW'(count_q) >= eff_cap);
  assign ins_ok    = acc_miss && (evict || free_found_q);

  always_comb begin
    if (evict && (!free_found_q || (old_idx_q < free_idx_q))) begin
      ins_idx = old_idx_q;
    end else begin
      ins_idx = free_idx_q;
    end
  end

  always_comb begin
    count_new = count_q;
    if (is_clear) begin
      count_new = '0;
    end else if (rem_hit) begin
      if (count_q != '0) begin
        count_new = count_q - CountW'(1);
      end
    end else if (acc_miss) begin
      count_new = count_q - CountW'(evict) + CountW'(ins_ok);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // request capture and scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_ACCESS;
      idx_q        <= '0;
      hit_found_q  <= 1'b0;
      old_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (accept) begin
      mode_q       <= mode_i;
      idx_q        <= '0;
      hit_found_q  <= 1'b0;
      old_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (state_q == ST_SCAN) begin
      idx_q <= idx_q + SlotIdxW'(1);
      if (cur_match && !hit_found_q) begin
        hit_found_q <= 1'b1;
      end
      if (cur_older) begin
        old_found_q <= 1'b1;
      end
      if (!cur_valid && !free_found_q) begin
        free_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_key_q  <= entry_key_i;
      req_page_q <= page_id_i;
    end else if (state_q == ST_SCAN) begin
      if (cur_match && !hit_found_q) begin
        hit_idx_q  <= idx_q;
        hit_rank_q <= cur_rank;
      end
      if (cur_older) begin
        old_idx_q  <= idx_q;
        old_rank_q <= cur_rank;
        old_key_q  <= key_mem[idx_q];
        old_page_q <= page_mem[idx_q];
      end
      if (!cur_valid && !free_found_q) begin
        free_idx_q <= idx_q;
      end
    end
  end

  // recency update, one lane per slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < NumSlots; i++) begin
        rank_q[i] <= '0;
      end
    end else if (state_q == ST_UPDATE) begin
      count_q <= count_new;
      for (int i = 0; i < NumSlots; i++) begin
        if (is_clear) begin
          valid_q[i] <= 1'b0;
          rank_q[i]  <= '0;
        end else if (acc_hit) begin
          if (SlotIdxW'(i) == hit_idx_q) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank_q)) begin
            rank_q[i] <= rank_q[i] + SlotIdxW'(1);
          end
        end else if (rem_hit) begin
          if (SlotIdxW'(i) == hit_idx_q) begin
            valid_q[i] <= 1'b0;
            rank_q[i]  <= '0;
          end else if (valid_q[i] && (rank_q[i] > hit_rank_q)) begin
            rank_q[i] <= rank_q[i] - SlotIdxW'(1);
          end
        end else if (acc_miss) begin
          if (ins_ok && (SlotIdxW'(i) == ins_idx)) begin
            valid_q[i] <= 1'b1;
            rank_q[i]  <= '0;
          end else if (evict && (SlotIdxW'(i) == old_idx_q)) begin
            valid_q[i] <= 1'b0;
            rank_q[i]  <= '0;
          end else if (valid_q[i]) begin
            rank_q[i] <= rank_q[i]
                         - SlotIdxW'(evict && (rank_q[i] > old_rank_q))
                         + SlotIdxW'(ins_ok);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_UPDATE) && ins_ok) begin
      key_mem[ins_idx]  <= req_key_q;
      page_mem[ins_idx] <= req_page_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (state_q == ST_UPDATE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPDATE) begin
      res_hit_q  <= acc_hit || rem_hit;
      res_ev_q   <= evict;
      res_key_q  <= evict ? old_key_q : '0;
      res_page_q <= evict ? old_page_q : '0;
      res_occ_q  <= OccW'(count_new);
    end
  end

  assign result_valid_o  = res_valid_q;
  assign hit_o           = res_hit_q;
  assign evicted_valid_o = res_ev_q;
  assign evicted_key_o   = res_key_q;
  assign evicted_page_o  = res_page_q;
  assign occupancy_o     = res_occ_q;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for lru_replacement_tracker: a queue-fed driver and a
// clocked monitor compare every result against an in-bench LRU page predictor.
// Depends on lrut_pkg and the lru_replacement_tracker RTL.
`timescale 1ns / 100ps

module testbench;
  import lrut_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int ReportMax = 10;
  localparam int PoolSize = 24;
  localparam int NumPhases = 11;
  localparam int PhaseLen = 60;
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  typedef enum logic [1:0] {
    STEP_REQUEST,
    STEP_CAPACITY,
    STEP_DRAIN
  } step_kind_e;

  typedef struct packed {
    step_kind_e       kind;
    logic [ModeW-1:0] mode;
    logic [KeyW-1:0]  key;
    logic [PageW-1:0] page;
    logic [CapW-1:0]  cap;
    logic [2:0]       gap;
  } step_t;

  typedef struct packed {
    logic             hit;
    logic             ev_valid;
    logic [KeyW-1:0]  ev_key;
    logic [PageW-1:0] ev_page;
    logic [OccW-1:0]  occupancy;
  } outcome_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CapW-1:0]  cfg_data = '0;
  logic             start = 1'b0;
  logic             busy;
  logic [ModeW-1:0] mode = MODE_ACCESS;
  logic [KeyW-1:0]  entry_key = '0;
  logic [PageW-1:0] page_id = '0;
  logic             result_valid;
  logic             hit;
  logic             evicted_valid;
  logic [KeyW-1:0]  evicted_key;
  logic [PageW-1:0] evicted_page;
  logic [OccW-1:0]  occupancy;

  step_t    pending_steps[$];
  outcome_t due_results[$];
  step_t    cur;
  logic     loaded = 1'b0;
  int       gap_left = 0;
  logic     gaps_on = 1'b1;
  int       mismatches = 0;
  int       cycle_count = 0;

  logic [KeyW-1:0]     trk_key[NumSlots];
  logic [PageW-1:0]    trk_page[NumSlots];
  logic [SlotIdxW-1:0] trk_rank[NumSlots];
  logic [NumSlots-1:0] trk_live = '0;
  logic [CountW-1:0]   trk_count = '0;
  logic [CapW-1:0]     trk_cap = CapReset;

  lru_replacement_tracker uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode),
    .entry_key_i    (entry_key),
    .page_id_i      (page_id),
    .result_valid_o (result_valid),
    .hit_o          (hit),
    .evicted_valid_o(evicted_valid),
    .evicted_key_o  (evicted_key),
    .evicted_page_o (evicted_page),
    .occupancy_o    (occupancy)
  );

  function automatic void retire_slot(input int s);
    logic [SlotIdxW-1:0] r;
    r = trk_rank[s];
    trk_live[s] = 1'b0;
    trk_rank[s] = '0;
    for (int i = 0; i < NumSlots; i++)
      if (trk_live[i] && trk_rank[i] > r) trk_rank[i] = trk_rank[i] - SlotIdxW'(1);
    if (trk_count != '0) trk_count = trk_count - CountW'(1);
  endfunction

  function automatic outcome_t lru_track(input step_t rq);
    outcome_t res;
    int slot;
    int old;
    logic [SlotIdxW-1:0] r;
    logic [CapW-1:0] eff;
    res = '0;
    slot = -1;
    for (int i = 0; i < NumSlots; i++)
      if (slot < 0 && trk_live[i] && trk_page[i] == rq.page) slot = i;
    case (rq.mode)
      MODE_ACCESS: begin
        if (slot >= 0) begin
          res.hit = 1'b1;
          r = trk_rank[slot];
          for (int i = 0; i < NumSlots; i++)
            if (trk_live[i] && trk_rank[i] < r) trk_rank[i] = trk_rank[i] + SlotIdxW'(1);
          trk_rank[slot] = '0;
        end else begin
          if (trk_cap == '0) eff = CapW'(1);
          else if (trk_cap > CapW'(NumSlots)) eff = CapW'(NumSlots);
          else eff = trk_cap;
          if (trk_count != '0 && CmpW'(trk_count) >= CmpW'(eff)) begin
            old = -1;
            for (int i = 0; i < NumSlots; i++)
              if (trk_live[i] && (old < 0 || trk_rank[i] >= trk_rank[old])) old = i;
            if (old >= 0) begin
              res.ev_valid = 1'b1;
              res.ev_key = trk_key[old];
              res.ev_page = trk_page[old];
              retire_slot(old);
            end
          end
          slot = -1;
          for (int i = 0; i < NumSlots; i++)
            if (slot < 0 && !trk_live[i]) slot = i;
          if (slot >= 0) begin
            for (int i = 0; i < NumSlots; i++)
              if (trk_live[i]) trk_rank[i] = trk_rank[i] + SlotIdxW'(1);
            trk_live[slot] = 1'b1;
            trk_key[slot] = rq.key;
            trk_page[slot] = rq.page;
            trk_rank[slot] = '0;
            trk_count = trk_count + CountW'(1);
          end
        end
      end
      MODE_REMOVE: begin
        if (slot >= 0) begin
          res.hit = 1'b1;
          retire_slot(slot);
        end
      end
      MODE_CLEAR: begin
        trk_live = '0;
        for (int i = 0; i < NumSlots; i++) trk_rank[i] = '0;
        trk_count = '0;
      end
      default: ;
    endcase
    res.occupancy = OccW'(trk_count);
    return res;
  endfunction

  task automatic queue_request(input logic [ModeW-1:0] m, input logic [KeyW-1:0] k,
                               input logic [PageW-1:0] pg);
    step_t s;
    s = '0;
    s.kind = STEP_REQUEST;
    s.mode = m;
    s.key = k;
    s.page = pg;
    if (gaps_on && $urandom_range(0, 3) == 0) s.gap = 3'($urandom_range(1, 7));
    pending_steps.push_back(s);
  endtask

  task automatic queue_capacity(input logic [CapW-1:0] c);
    step_t s;
    s = '0;
    s.kind = STEP_CAPACITY;
    s.cap = c;
    pending_steps.push_back(s);
  endtask

  task automatic check_field(input string field, input logic [KeyW-1:0] want,
                             input logic [KeyW-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= ReportMax)
        $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endtask

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  initial begin : reset_gen
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic took;
    logic settled;
    logic nx_start;
    logic nx_we;
    logic [CapW-1:0] nx_data;
    step_t nx;
    if (!rst_ni) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      cfg_data <= '0;
    end else begin
      took = start && !busy;
      settled = !start && !took && !result_valid && due_results.size() == 0;
      nx_start = start && !took;
      nx_we = 1'b0;
      nx_data = cfg_data;
      if (took) due_results.push_back(lru_track(cur));
      if (!nx_start) begin
        if (loaded) begin
          if (gap_left != 0) begin
            if (!busy) gap_left--;
          end else begin
            nx_start = 1'b1;
            loaded = 1'b0;
          end
        end else if (pending_steps.size() != 0) begin
          nx = pending_steps[0];
          case (nx.kind)
            STEP_REQUEST: begin
              void'(pending_steps.pop_front());
              cur = nx;
              mode <= nx.mode;
              entry_key <= nx.key;
              page_id <= nx.page;
              if (nx.gap == '0) begin
                nx_start = 1'b1;
              end else begin
                gap_left = int'(nx.gap);
                loaded = 1'b1;
              end
            end
            STEP_CAPACITY: begin
              if (settled && !busy) begin
                void'(pending_steps.pop_front());
                nx_we = 1'b1;
                nx_data = nx.cap;
                trk_cap = nx.cap;
              end
            end
            STEP_DRAIN: begin
              if (settled) void'(pending_steps.pop_front());
            end
            default: ;
          endcase
        end
      end
      start <= nx_start;
      cfg_we <= nx_we;
      cfg_data <= nx_data;
    end
  end

  always @(posedge clk_i) begin : watch
    outcome_t want;
    if (rst_ni && result_valid === 1'b1) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("mismatch: result with none due, occupancy %0d", occupancy);
      end else begin
        want = due_results.pop_front();
        check_field("hit", KeyW'(want.hit), KeyW'(hit));
        check_field("evicted_valid", KeyW'(want.ev_valid), KeyW'(evicted_valid));
        check_field("evicted_key", want.ev_key, evicted_key);
        check_field("evicted_page", KeyW'(want.ev_page), KeyW'(evicted_page));
        check_field("occupancy", KeyW'(want.occupancy), KeyW'(occupancy));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [PageW-1:0] pool[PoolSize];
    logic [CapW-1:0] phase_caps[NumPhases];
    logic [ModeW-1:0] m;
    logic [PageW-1:0] pg;
    step_t hold_step;
    int span;
    int pick;
    phase_caps = '{5'd16, 5'd3, 5'd1, 5'd31, 5'd0, 5'd8, 5'd2, 5'd16, 5'd17, 5'd12, 5'd5};
    foreach (pool[i]) pool[i] = PageW'($urandom);
    hold_step = '0;
    hold_step.kind = STEP_DRAIN;

    queue_request(MODE_ACCESS, 64'h8000_0000_0000_0000, 16'h0000);
    queue_request(MODE_ACCESS, 64'h7FFF_FFFF_FFFF_FFFF, 16'hFFFF);
    queue_request(MODE_ACCESS, 64'h0123_4567_89AB_CDEF, 16'h0000);
    queue_request(MODE_ACCESS, 64'hFFFF_FFFF_FFFF_FFFF, 16'h5A5A);
    queue_request(MODE_REMOVE, 64'h0, 16'hFFFF);
    queue_request(MODE_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h1234);
    queue_request(ModeUnused, 64'hA5A5_A5A5_A5A5_A5A5, 16'h0000);
    queue_request(MODE_CLEAR, 64'h5A5A_5A5A_5A5A_5A5A, 16'h5A5A);
    queue_request(MODE_ACCESS, 64'h0, 16'h0007);
    queue_request(MODE_REMOVE, 64'h0, 16'h0007);
    queue_request(MODE_REMOVE, 64'h0, 16'h0007);
    queue_capacity(5'd1);
    queue_request(MODE_ACCESS, 64'hA5A5_0000_FFFF_5A5A, 16'hAAAA);
    queue_request(MODE_ACCESS, 64'h5A5A_FFFF_0000_A5A5, 16'h5555);
    queue_request(MODE_ACCESS, 64'h0, 16'h5555);
    queue_capacity(5'd0);
    queue_request(MODE_ACCESS, 64'h1, 16'h0001);
    queue_request(MODE_ACCESS, 64'h2, 16'h0002);
    queue_capacity(5'd31);
    queue_request(MODE_ACCESS, 64'h3, 16'h0003);

    for (int p = 0; p < NumPhases; p++) begin
      if (p >= NumPhases - 2) gaps_on = 1'b0;
      queue_capacity(phase_caps[p]);
      if (phase_caps[p] == '0) span = 1;
      else if (phase_caps[p] > CapW'(NumSlots)) span = NumSlots;
      else span = int'(phase_caps[p]);
      span += 4;
      for (int n = 0; n < PhaseLen; n++) begin
        if (n == PhaseLen / 2) pending_steps.push_back(hold_step);
        pick = $urandom_range(0, 99);
        if (pick < 75) m = MODE_ACCESS;
        else if (pick < 93) m = MODE_REMOVE;
        else if (pick < 96) m = MODE_CLEAR;
        else m = ModeUnused;
        if ($urandom_range(0, 9) == 0) pg = PageW'($urandom);
        else pg = pool[$urandom_range(0, span - 1)];
        if (p == 0 && n < 20) begin
          m = MODE_ACCESS;
          pg = PageW'($urandom);
        end
        queue_request(m, {$urandom, $urandom}, pg);
      end
    end

    while (pending_steps.size() != 0 || due_results.size() != 0 || start || loaded)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
